[hw/rtl/cfgp_pkg.sv]
// Package for the conflict-free group partition core.
// Holds widths, reset values, the sequencer state type and the scan unit structs.
// No dependencies.
package cfgp_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;  // default element capacity
  localparam int LIMIT_CAP        = 16;  // rows are 16 bits wide, so never more than this
  localparam int ROW_W            = 16;  // conflict row width
  localparam int CNT_W            = 5;   // element count / rows loaded width
  localparam int IDX_OUT_W        = 4;   // element index port width
  localparam int GRP_W            = 5;   // group number width

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // One candidate presented to the shared scan unit.
  typedef struct packed {
    logic [ROW_W-1:0] unassigned;  // elements without a group yet
    logic [ROW_W-1:0] clash;       // OR of rows taken this round
    logic [ROW_W-1:0] cand;        // one-hot candidate element
    logic [ROW_W-1:0] row;         // candidate's conflict row, masked to the count
  } scan_req_t;

  typedef struct packed {
    logic             take;        // candidate joins the current group
    logic [ROW_W-1:0] unassigned;
    logic [ROW_W-1:0] clash;
  } scan_rsp_t;

endpackage

[hw/rtl/conflict_free_group_partition_core.sv]
// Conflict-free group partition core: loads a conflict matrix row by row and
// then splits the elements into groups by greedy rounds.
// Depends on cfgp_pkg, cfgp_row_store and cfgp_scan_unit.
//
//   channel  | handshake                         | payload
//   ---------+-----------------------------------+-------------------------------------
//   row in   | start_i, busy_o (take: !busy_o)   | conflict_row_i[15:0]
//   config   | cfg_valid_i, cfg_ready_o          | cfg_data_i[4:0] (element_count)
//   result   | result_valid_o (one-cycle strobe) | element_index_o, group_number_o,
//            |                                   | last_result_o
//
// A row that does not complete the batch leaves busy_o low. The completing
// row starts the partition: each round visits elements 0..N-1 in order
// through the shared scan unit, for R rounds (R <= N), then N results
// follow, one strobe each. Reset clears the sequencer, the row counter and
// the count register (16); matrix and group table hold no reset. Results
// cannot be stalled.

module conflict_free_group_partition_core #(
  parameter int MAX_ELEMENTS = cfgp_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // row requests
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [cfgp_pkg::ROW_W-1:0]     conflict_row_i,
  // config write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfgp_pkg::CNT_W-1:0]     cfg_data_i,
  // results
  output logic                           result_valid_o,
  output logic [cfgp_pkg::IDX_OUT_W-1:0] element_index_o,
  output logic [cfgp_pkg::GRP_W-1:0]     group_number_o,
  output logic                           last_result_o
);

  // usable element count: capped by the row width
  localparam int LIM   = (MAX_ELEMENTS < cfgp_pkg::LIMIT_CAP) ? MAX_ELEMENTS
                                                                : cfgp_pkg::LIMIT_CAP;
  localparam int IDX_W = $clog2(LIM);
  localparam logic [cfgp_pkg::CNT_W-1:0] LIM_CNT = cfgp_pkg::CNT_W'(LIM);

  cfgp_pkg::state_e state_q, state_d;

  logic [cfgp_pkg::CNT_W-1:0] count_q;      // element_count register
  logic [cfgp_pkg::CNT_W-1:0] rows_q, rows_d;
  logic [cfgp_pkg::ROW_W-1:0] unasg_q, unasg_d;
  logic [cfgp_pkg::ROW_W-1:0] clash_q, clash_d;
  logic [cfgp_pkg::GRP_W-1:0] grp_q, grp_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [cfgp_pkg::GRP_W-1:0] gtab_q [LIM];
  logic                       gtab_we;

  logic [cfgp_pkg::CNT_W-1:0] eff_cnt;
  logic [cfgp_pkg::CNT_W-1:0] rows_inc;
  logic [IDX_W-1:0]           last_idx;
  logic [cfgp_pkg::ROW_W-1:0] all_mask;
  logic [cfgp_pkg::ROW_W-1:0] row_rd;
  logic                       accept;
  logic                       load_done;
  logic                       row_we;
  logic                       at_last;

  cfgp_pkg::scan_req_t scan_req;
  cfgp_pkg::scan_rsp_t scan_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cfgp_pkg::COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything above the capacity acts as the capacity
  always_comb begin
    if (count_q == '0) begin
      eff_cnt = cfgp_pkg::CNT_W'(1);
    end else if (count_q > LIM_CNT) begin
      eff_cnt = LIM_CNT;
    end else begin
      eff_cnt = count_q;
    end
  end

  assign last_idx = IDX_W'(eff_cnt - cfgp_pkg::CNT_W'(1));
  assign all_mask = ~({cfgp_pkg::ROW_W{1'b1}} << eff_cnt);  // low eff_cnt bits

  // ---------------------------------------------------------------- row load
  assign busy_o    = (state_q != cfgp_pkg::ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign rows_inc  = rows_q + cfgp_pkg::CNT_W'(1);
  assign load_done = (rows_inc >= eff_cnt);     // count may have dropped mid-batch
  assign row_we    = accept && (rows_q < LIM_CNT);
  assign at_last   = (idx_q == last_idx);

  // the read address follows idx_d so the row for idx_q is ready in the scan cycle
  cfgp_row_store #(
    .DEPTH (LIM),
    .IDX_W (IDX_W)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (rows_q[IDX_W-1:0]),
    .wdata_i (conflict_row_i),
    .raddr_i (idx_d),
    .rdata_o (row_rd)
  );

  // ---------------------------------------------------------------- scan unit
  always_comb begin
    scan_req.unassigned = unasg_q;
    scan_req.clash      = clash_q;
    scan_req.cand       = cfgp_pkg::ROW_W'(1) << idx_q;
    scan_req.row        = row_rd & all_mask;   // row bits beyond the count ignored
  end

  cfgp_scan_unit u_scan_unit (
    .req_i (scan_req),
    .rsp_o (scan_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      cfgp_pkg::ST_IDLE: begin
        if (accept && load_done) state_d = cfgp_pkg::ST_SCAN;
      end
      cfgp_pkg::ST_SCAN: begin
        // partition done once a round ends with nothing left
        if (at_last && (scan_rsp.unassigned == '0)) state_d = cfgp_pkg::ST_EMIT;
      end
      cfgp_pkg::ST_EMIT: begin
        if (at_last) state_d = cfgp_pkg::ST_IDLE;
      end
      default: state_d = cfgp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rows_d  = rows_q;
    unasg_d = unasg_q;
    clash_d = clash_q;
    grp_d   = grp_q;
    idx_d   = idx_q;
    gtab_we = 1'b0;
    case (state_q)
      cfgp_pkg::ST_IDLE: begin
        if (accept) begin
          rows_d = rows_inc;
          if (load_done) begin
            rows_d  = '0;
            unasg_d = all_mask;
            clash_d = '0;
            grp_d   = cfgp_pkg::GRP_W'(1);
            idx_d   = '0;
          end
        end
      end
      cfgp_pkg::ST_SCAN: begin
        unasg_d = scan_rsp.unassigned;
        clash_d = scan_rsp.clash;
        gtab_we = scan_rsp.take;
        if (at_last) begin
          idx_d = '0;
          if (scan_rsp.unassigned != '0) begin
            // next round: new group, fresh clash mask
            grp_d   = grp_q + cfgp_pkg::GRP_W'(1);
            clash_d = '0;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      cfgp_pkg::ST_EMIT: begin
        idx_d = at_last ? '0 : idx_q + IDX_W'(1);
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfgp_pkg::ST_IDLE;
      rows_q  <= '0;
      unasg_q <= '0;
      clash_q <= '0;
      grp_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      unasg_q <= unasg_d;
      clash_q <= clash_d;
      grp_q   <= grp_d;
      idx_q   <= idx_d;
    end
  end

  // group table, written as each element is taken
  always_ff @(posedge clk_i) begin
    if (gtab_we) begin
      gtab_q[idx_q] <= grp_q;
    end
  end

  // ---------------------------------------------------------------- results
  assign result_valid_o  = (state_q == cfgp_pkg::ST_EMIT);
  assign element_index_o = cfgp_pkg::IDX_OUT_W'(idx_q);
  assign group_number_o  = gtab_q[idx_q];
  assign last_result_o   = result_valid_o && at_last;

`ifndef SYNTHESIS
  // results only while the core reports busy
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // results run back to back until the last one
  a_result_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=> result_valid_o)
    else $error("gap in result sequence");

  // core frees up right after the last result
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> !busy_o)
    else $error("still busy after last result");

  // every element got a group
  a_group_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (group_number_o != '0))
    else $error("element left without a group");
`endif

endmodule

[hw/rtl/cfgp_row_store.sv]
// Conflict matrix storage: one row per element, one write and one registered read.
// Depends on cfgp_pkg for the row width and the default depth.
module cfgp_row_store #(
  parameter int DEPTH = cfgp_pkg::MAX_ELEMENTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [IDX_W-1:0]           waddr_i,
  input  logic [cfgp_pkg::ROW_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]           raddr_i,
  output logic [cfgp_pkg::ROW_W-1:0] rdata_o
);

  logic [cfgp_pkg::ROW_W-1:0] mem [DEPTH];
  logic [cfgp_pkg::ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first: a row written this cycle is seen by the read of the same address
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cfgp_scan_unit.sv]
// Shared scan step: decides whether one candidate joins the current group
// and updates the unassigned and clash masks. Depends on cfgp_pkg.
module cfgp_scan_unit (
  input  cfgp_pkg::scan_req_t req_i,
  output cfgp_pkg::scan_rsp_t rsp_o
);

  logic take;

  assign take = |(req_i.unassigned & req_i.cand & ~req_i.clash);

  always_comb begin
    rsp_o.take       = take;
    rsp_o.unassigned = req_i.unassigned;
    rsp_o.clash      = req_i.clash;
    if (take) begin
      rsp_o.unassigned = req_i.unassigned & ~req_i.cand;
      rsp_o.clash      = req_i.clash | req_i.row;
    end
  end

endmodule

[tb/tb_conflict_free_group_partition_core.sv]
// Self-checking testbench for conflict_free_group_partition_core.
// Drives row and count requests from a queue, predicts each partition and checks every result.
// Depends on cfgp_pkg and the core RTL only.
module tb_conflict_free_group_partition_core;

  localparam int          ROW_W       = cfgp_pkg::ROW_W;
  localparam int          CNT_W       = cfgp_pkg::CNT_W;
  localparam int          IDX_OUT_W   = cfgp_pkg::IDX_OUT_W;
  localparam int          GRP_W       = cfgp_pkg::GRP_W;
  localparam logic [CNT_W-1:0] COUNT_RESET = cfgp_pkg::COUNT_RESET;
  localparam int          USABLE      = (cfgp_pkg::MAX_ELEMENTS_DEF < cfgp_pkg::LIMIT_CAP)
                                        ? cfgp_pkg::MAX_ELEMENTS_DEF : cfgp_pkg::LIMIT_CAP;
  localparam int          RANDOM_ROWS = 480;
  localparam int unsigned DRAIN       = 4;       // idle cycles before a count write or a marked row
  localparam int unsigned TAIL        = 300;
  localparam int unsigned LIMIT       = 200000;  // cycle budget, several times the slowest run
  localparam int unsigned MAX_SHOWN   = 10;

  // One request for the sender: either a matrix row or an element_count write.
  typedef struct {
    bit               is_cfg;
    bit               hold_idle;  // wait until every pending result is out
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] count;
    int unsigned      gap;
  } row_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [GRP_W-1:0]     grp;
    logic                 last;
  } grp_result_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic [ROW_W-1:0]     conflict_row_i = '0;
  logic                 cfg_valid_i    = 1'b0;
  logic [CNT_W-1:0]     cfg_data_i     = '0;
  logic                 busy_o;
  logic                 cfg_ready_o;
  logic                 result_valid_o;
  logic [IDX_OUT_W-1:0] element_index_o;
  logic [GRP_W-1:0]     group_number_o;
  logic                 last_result_o;

  conflict_free_group_partition_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .conflict_row_i  (conflict_row_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .element_index_o (element_index_o),
    .group_number_o  (group_number_o),
    .last_result_o   (last_result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Partition predictor: own copy of count register, matrix and row counter.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_reg = COUNT_RESET;
  logic [ROW_W-1:0] matrix [USABLE];
  logic [CNT_W-1:0] rows_loaded = '0;

  row_req_t    row_reqs[$];
  grp_result_t expected_groups[$];

  int unsigned total_reqs    = 0;
  int unsigned accepted_reqs = 0;
  int unsigned row_count     = 0;
  int unsigned cfg_count     = 0;
  int unsigned partitions    = 0;
  int unsigned checked       = 0;
  int unsigned fail_count    = 0;
  int unsigned most_groups   = 0;
  int unsigned cycles        = 0;
  logic [16:0] counts_seen   = '0;

  // 0 acts as 1, anything above the usable size acts as that size
  function automatic int unsigned effective_count(input logic [CNT_W-1:0] c);
    if (c == '0) return 1;
    if (int'(c) > USABLE) return USABLE;
    return int'(c);
  endfunction

  // Store one row; when the batch reaches the count, run the greedy rounds and
  // queue one result per element in index order.
  task automatic predict_partition(input logic [ROW_W-1:0] row);
    int unsigned      n;
    logic [ROW_W-1:0] all_mask, open_mask, clash_mask;
    logic [GRP_W-1:0] grp;
    logic [GRP_W-1:0] grp_of [USABLE];
    grp_result_t      res;
    n = effective_count(count_reg);
    if (int'(rows_loaded) < USABLE) matrix[rows_loaded[3:0]] = row;
    rows_loaded = rows_loaded + 1'b1;
    if (rows_loaded < n) return;
    rows_loaded = '0;
    all_mask  = ROW_W'((17'd1 << n) - 17'd1);
    open_mask = all_mask;
    grp       = '0;
    while (open_mask != '0) begin
      grp++;
      clash_mask = '0;
      // a candidate is tested only against rows already taken this round
      for (int i = 0; i < n; i++) begin
        if (open_mask[i] && !clash_mask[i]) begin
          grp_of[i]    = grp;
          open_mask[i] = 1'b0;
          clash_mask   = clash_mask | (matrix[i] & all_mask);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      res.idx  = IDX_OUT_W'(i);
      res.grp  = grp_of[i];
      res.last = (i == n - 1);
      expected_groups.push_back(res);
    end
    partitions++;
    counts_seen[n] = 1'b1;
    if (grp > most_groups) most_groups = grp;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one request at a time, random gap before each. Count writes and
  // marked rows wait until the core has drained.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : row_sender
    logic        nxt_start, nxt_cfg;
    row_req_t    cur;
    bit          armed;
    int unsigned gap_left, quiet;
    if (!rst_ni) begin
      start_i        <= 1'b0;
      cfg_valid_i    <= 1'b0;
      conflict_row_i <= '0;
      cfg_data_i     <= '0;
      armed    = 1'b0;
      gap_left = 0;
      quiet    = 0;
    end else begin
      nxt_start = start_i;
      nxt_cfg   = cfg_valid_i;
      if (start_i && !busy_o) begin
        predict_partition(conflict_row_i);
        nxt_start = 1'b0;
        quiet     = 0;
        row_count++;
        accepted_reqs++;
      end else if (expected_groups.size() == 0) begin
        if (quiet < DRAIN) quiet++;
      end else begin
        quiet = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        count_reg = cfg_data_i;
        nxt_cfg   = 1'b0;
        cfg_count++;
        accepted_reqs++;
      end
      if (!nxt_start && !nxt_cfg && row_reqs.size() != 0) begin
        if (!armed) begin
          gap_left = row_reqs[0].gap;
          armed    = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(row_reqs[0].is_cfg || row_reqs[0].hold_idle) ||
                     (expected_groups.size() == 0 && quiet >= DRAIN)) begin
          cur   = row_reqs.pop_front();
          armed = 1'b0;
          if (cur.is_cfg) begin
            nxt_cfg = 1'b1;
            cfg_data_i <= cur.count;
          end else begin
            nxt_start = 1'b1;
            conflict_row_i <= cur.row;
          end
        end
      end
      // single assignment per edge keeps back-to-back requests glitch free
      start_i     <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: strobed results against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    grp_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_groups.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected result: idx %0d grp %0d last %0b",
                   element_index_o, group_number_o, last_result_o);
      end else begin
        want = expected_groups.pop_front();
        checked++;
        if (element_index_o !== want.idx || group_number_o !== want.grp ||
            last_result_o !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: exp idx %0d grp %0d last %0b, got idx %0d grp %0d last %0b",
                     want.idx, want.grp, want.last,
                     element_index_o, group_number_o, last_result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_groups.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_row(input logic [ROW_W-1:0] row, input int unsigned gap,
                          input bit hold_idle);
    row_req_t r;
    r.is_cfg    = 1'b0;
    r.hold_idle = hold_idle;
    r.row       = row;
    r.count     = '0;
    r.gap       = gap;
    row_reqs.push_back(r);
  endtask

  task automatic push_cfg(input logic [CNT_W-1:0] count, input int unsigned gap);
    row_req_t r;
    r.is_cfg    = 1'b1;
    r.hold_idle = 1'b1;
    r.row       = '0;
    r.count     = count;
    r.gap       = gap;
    row_reqs.push_back(r);
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return ROW_W'($urandom);
      3:       return ROW_W'($urandom & $urandom);
      4:       return ROW_W'($urandom | $urandom);
      default: return ROW_W'($urandom & $urandom & $urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] forced [6];
    logic [CNT_W-1:0] c;
    logic [ROW_W-1:0] rows [USABLE];
    logic [ROW_W-1:0] all_mask;
    int unsigned      n, batches, k, left, density, rnd_rows, gap;
    bit               burst, first;

    // -- directed --------------------------------------------------------------
    // count 0 acts as 1; self conflict and bits beyond the count are ignored
    push_cfg(5'd0, 0);
    push_row(16'hFFFF, 0, 1'b0);
    push_row(16'h0000, 1, 1'b0);
    push_cfg(5'd1, 0);
    push_row(16'h0001, 0, 1'b0);
    // non-symmetric: 0 blocks 1, 1 blocks 2, row of 2 empty
    push_cfg(5'd3, 2);
    push_row(16'h0002, 0, 1'b0);
    push_row(16'h0004, 0, 1'b0);
    push_row(16'h0000, 0, 1'b0);
    // complete graph: one group per element
    push_row(16'hFFFF, 3, 1'b0);
    push_row(16'hFFFF, 0, 1'b0);
    push_row(16'hFFFF, 0, 1'b0);
    // count lowered mid-batch: next row fires the partition at once
    push_cfg(5'd5, 0);
    push_row(16'h001E, 0, 1'b0);
    push_row(16'h0001, 0, 1'b0);
    push_cfg(5'd2, 1);
    push_row(16'h0003, 0, 1'b0);
    // count raised mid-batch: loaded row kept
    push_row(16'h0002, 0, 1'b0);
    push_cfg(5'd4, 0);
    push_row(16'h0005, 0, 1'b0);
    push_row(16'h000A, 2, 1'b0);
    push_row(16'h0005, 0, 1'b0);
    push_cfg(5'd2, 0);
    push_row(16'h0002, 0, 1'b0);
    push_row(16'h0001, 0, 1'b0);

    // -- random phases ---------------------------------------------------------
    forced = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd15};
    rnd_rows = 0;
    first    = 1'b1;
    for (int p = 0; rnd_rows < RANDOM_ROWS; p++) begin
      if (p < 6) c = forced[p];
      else if ($urandom_range(0, 9) < 7) c = CNT_W'($urandom_range(1, 8));
      else c = CNT_W'($urandom_range(0, 31));
      push_cfg(c, $urandom_range(0, 6));
      n       = effective_count(c);
      burst   = ($urandom_range(0, 3) == 0);
      batches = (n > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      for (int b = 0; b < batches; b++) begin
        // broken batch: part of the rows, then a new count
        if (n >= 2 && $urandom_range(0, 9) == 0) begin
          k = $urandom_range(1, n - 1);
          for (int i = 0; i < k; i++) begin
            push_row(random_row(), burst ? 0 : $urandom_range(0, 6), 1'b0);
            rnd_rows++;
          end
          c = CNT_W'($urandom_range(0, 31));
          push_cfg(c, $urandom_range(0, 6));
          n    = effective_count(c);
          left = (k >= n) ? 1 : n - k;
          for (int i = 0; i < left; i++) begin
            push_row(random_row(), burst ? 0 : $urandom_range(0, 6), 1'b0);
            rnd_rows++;
          end
          continue;
        end
        all_mask = ROW_W'((17'd1 << n) - 17'd1);
        if ($urandom_range(0, 1) == 0) begin
          // undirected graph of random density plus noise above the count
          density = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) rows[i] = '0;
          for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
              if ($urandom_range(0, 3) < density) begin
                rows[i][j] = 1'b1;
                rows[j][i] = 1'b1;
              end
            end
            rows[i][i] = 1'($urandom_range(0, 1));
          end
          for (int i = 0; i < n; i++) rows[i] = rows[i] | (ROW_W'($urandom) & ~all_mask);
        end else begin
          for (int i = 0; i < n; i++) rows[i] = random_row();
        end
        for (int i = 0; i < n; i++) begin
          gap = burst ? 0 : $urandom_range(0, 6);
          push_row(rows[i], gap, first || ($urandom_range(0, 39) == 0));
          first = 1'b0;
          rnd_rows++;
        end
      end
    end
    total_reqs = row_reqs.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_reqs == total_reqs);
    while (expected_groups.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Summary: %0d rows, %0d count writes, %0d partitions, %0d results checked",
             row_count, cfg_count, partitions, checked);
    $display("  %0d distinct element counts, up to %0d groups in one partition, %0d failures",
             $countones(counts_seen), most_groups, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
